[sv/scr_pkg.sv]
// Shared types, constants and helper functions for the shunt current regulator.
package scr_pkg;

	// Upper limit of both pot positions.
	localparam int unsigned POT_TOP = 63;
	// Positions are stored just wide enough to hold the pot top.
	localparam int unsigned POS_W = $clog2(POT_TOP + 1);

	localparam int unsigned CMD_W = 3;
	localparam int unsigned CUR_W = 10;
	localparam int unsigned MV_W = 16;
	localparam int unsigned SET_W = 6;
	localparam int unsigned LED_W = 2;
	localparam int unsigned CNT_W = 8;
	// Pot writes are formed at this width before clamping.
	localparam int unsigned CALC_W = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 10;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SHUNT_UP = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SHUNT_DOWN = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GAIN_DOWN = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GAIN_UP = 3'd4;

	// LED codes.
	localparam logic [LED_W-1:0] LED_OFF = 2'd0;
	localparam logic [LED_W-1:0] LED_GREEN = 2'd1;
	localparam logic [LED_W-1:0] LED_RED = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CURRENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE = 1'd1;

	// Regulation constants.
	localparam logic [CALC_W-1:0] PARK_RAW = 8'd20;
	localparam logic [MV_W-1:0] FULL_MV = 16'd3600;
	localparam logic [CUR_W-1:0] TRIP_LIMIT = 10'd750;
	localparam logic [CUR_W:0] DEADBAND = 11'd100;
	localparam logic [CALC_W-1:0] SHUNT_BACKOFF = 8'd10;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [CALC_W-1:0] POT_TOP_C = CALC_W'(POT_TOP);

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [CUR_W-1:0] measured_current;
		logic [MV_W-1:0] cell_voltage;
	} in_t;

	typedef struct packed {
		logic [SET_W-1:0] gain_setting;
		logic [SET_W-1:0] shunt_setting;
		logic [LED_W-1:0] led_state;
		logic [CNT_W-1:0] overcurrent_count;
	} out_t;

	typedef struct packed {
		logic [CUR_W-1:0] target_current;
		logic auto_mode;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] gain_pos;
		logic [POS_W-1:0] shunt_pos;
		logic [CNT_W-1:0] trip_count;
	} state_t;

	// Clamp an 8-bit pot write to the pot top.
	function automatic logic [POS_W-1:0] pot_value(input logic [CALC_W-1:0] v);
		logic [CALC_W-1:0] c;
		c = (v > POT_TOP_C) ? POT_TOP_C : v;
		return c[POS_W-1:0];
	endfunction

	// Widen a stored position to the 8-bit write width.
	function automatic logic [CALC_W-1:0] pos_wide(input logic [POS_W-1:0] p);
		return CALC_W'(p);
	endfunction

	// The output setting carries the low bits of the position.
	function automatic logic [SET_W-1:0] to_setting(input logic [POS_W-1:0] p);
		logic [CALC_W-1:0] w;
		w = CALC_W'(p);
		return w[SET_W-1:0];
	endfunction

	localparam logic [POS_W-1:0] PARK_POS = pot_value(PARK_RAW);

endpackage

[sv/scr_step.sv]
// Next-state and result logic for one command of the shunt current regulator.
module scr_step (
	input  scr_pkg::cfg_t   cfg,
	input  scr_pkg::state_t cur,
	input  scr_pkg::in_t    item,
	output scr_pkg::state_t nxt,
	output scr_pkg::out_t   res
);

	logic [scr_pkg::CUR_W:0] meas_w;
	logic [scr_pkg::CUR_W:0] tgt_w;
	logic                    below_band;
	logic                    above_band;
	logic [scr_pkg::POS_W-1:0] backoff_pos;
	logic [scr_pkg::POS_W-1:0] shunt_inc;
	logic [scr_pkg::POS_W-1:0] shunt_dec;
	logic [scr_pkg::POS_W-1:0] gain_inc;
	logic [scr_pkg::POS_W-1:0] gain_dec;
	logic [scr_pkg::LED_W-1:0] led;

	// Deadband compare on the current error, done without a signed subtract.
	assign meas_w = {1'b0, item.measured_current};
	assign tgt_w = {1'b0, cfg.target_current};
	assign below_band = (meas_w + scr_pkg::DEADBAND) <= tgt_w;
	assign above_band = meas_w >= (tgt_w + scr_pkg::DEADBAND);

	// Candidate pot writes, each formed at 8 bits and clamped.
	assign backoff_pos = scr_pkg::pot_value(scr_pkg::pos_wide(cur.shunt_pos)
		- scr_pkg::SHUNT_BACKOFF);
	assign shunt_inc = scr_pkg::pot_value(scr_pkg::pos_wide(cur.shunt_pos) + 8'd1);
	assign shunt_dec = scr_pkg::pot_value(scr_pkg::pos_wide(cur.shunt_pos) - 8'd1);
	assign gain_inc = scr_pkg::pot_value(scr_pkg::pos_wide(cur.gain_pos) + 8'd1);
	assign gain_dec = scr_pkg::pot_value(scr_pkg::pos_wide(cur.gain_pos) - 8'd1);

	// Command decode and automatic regulation.
	always_comb begin
		nxt = cur;
		unique case (item.cmd)
			scr_pkg::CMD_TICK: begin
				if (cfg.auto_mode) begin
					if (cfg.target_current == '0) begin
						nxt.gain_pos = scr_pkg::PARK_POS;
						nxt.shunt_pos = scr_pkg::PARK_POS;
					end else if (item.measured_current > scr_pkg::TRIP_LIMIT) begin
						nxt.gain_pos = scr_pkg::PARK_POS;
						nxt.shunt_pos = scr_pkg::PARK_POS;
						if (cur.trip_count != scr_pkg::COUNT_MAX) begin
							nxt.trip_count = cur.trip_count + 8'd1;
						end
					end else if (below_band) begin
						if (scr_pkg::pos_wide(cur.shunt_pos) >= scr_pkg::POT_TOP_C) begin
							// A pot at the top backs off and borrows a gain step.
							nxt.shunt_pos = scr_pkg::pot_value(scr_pkg::pos_wide(backoff_pos)
								+ 8'd1);
							nxt.gain_pos = gain_inc;
						end else begin
							nxt.shunt_pos = shunt_inc;
						end
					end else if (above_band) begin
						nxt.shunt_pos = shunt_dec;
					end
				end
			end
			scr_pkg::CMD_SHUNT_UP:   nxt.shunt_pos = shunt_inc;
			scr_pkg::CMD_SHUNT_DOWN: nxt.shunt_pos = shunt_dec;
			scr_pkg::CMD_GAIN_DOWN:  nxt.gain_pos = gain_dec;
			scr_pkg::CMD_GAIN_UP:    nxt.gain_pos = gain_inc;
			default: ;
		endcase
	end

	// LED choice: red while shunting, green for a full cell, otherwise off.
	always_comb begin
		priority if (cfg.target_current != '0) begin
			led = scr_pkg::LED_RED;
		end else if (item.cell_voltage > scr_pkg::FULL_MV) begin
			led = scr_pkg::LED_GREEN;
		end else begin
			led = scr_pkg::LED_OFF;
		end
	end

	// Result reports the state after this command.
	assign res.gain_setting = scr_pkg::to_setting(nxt.gain_pos);
	assign res.shunt_setting = scr_pkg::to_setting(nxt.shunt_pos);
	assign res.led_state = led;
	assign res.overcurrent_count = nxt.trip_count;

endmodule

[sv/shunt_current_regulator_core.sv]
// Top level of the shunt current regulator: input register, step logic, result register.
//
// Usage: commands arrive on the in_valid/in_ready channel as an scr_pkg::in_t
// (command, measured current, cell voltage). Every command yields exactly one
// result on the out_valid/out_ready channel as an scr_pkg::out_t (gain and
// shunt pot settings, LED code, overcurrent count), in order.
// Configuration (target current, automatic mode) is written through the
// cfg_valid/cfg_ready channel, which is always ready; write it only while no
// command is in flight.
// A command is captured in the input register, and its result then waits in the
// result register until the receiver takes it.
// Throughput: one command per cycle unless the receiver stalls. The pot state updates as a
// command leaves the input register, so the next command sees it at once.
// When the receiver stalls, the result register holds and the input register
// still takes one more command; in_ready falls only when both are full.
// Reset clears both stages, parks both pots at 20, zeroes the overcurrent
// count, sets the target current to zero and turns automatic mode on.
module shunt_current_regulator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  scr_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output scr_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [scr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	scr_pkg::cfg_t   cfg_q;
	scr_pkg::state_t state_q;
	scr_pkg::state_t state_nxt;
	scr_pkg::in_t    item_s1;
	logic            valid_s1;
	scr_pkg::out_t   res_s2;
	scr_pkg::out_t   res_nxt;
	logic            valid_s2;
	logic            load_s2;
	logic            adv_s1;

	// Handshake flow between the two stages.
	assign load_s2 = !valid_s2 || out_ready;
	assign adv_s1 = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data = res_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_current <= '0;
			cfg_q.auto_mode <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scr_pkg::CFG_TARGET_CURRENT:
					cfg_q.target_current <= cfg_data[scr_pkg::CUR_W-1:0];
				scr_pkg::CFG_AUTO_MODE: cfg_q.auto_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	scr_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Pot positions and trip count advance with each command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.gain_pos <= scr_pkg::PARK_POS;
			state_q.shunt_pos <= scr_pkg::PARK_POS;
			state_q.trip_count <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// The pot state only moves when a command leaves the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("pot state changed without a command");

	// Positions never pass the pot top.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(scr_pkg::pos_wide(state_q.gain_pos) <= scr_pkg::POT_TOP_C)
		&& (scr_pkg::pos_wide(state_q.shunt_pos) <= scr_pkg::POT_TOP_C))
		else $error("pot position above top");

	// The trip count steps by at most one and never falls.
	a_trip_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (state_q.trip_count == $past(state_q.trip_count))
		|| (state_q.trip_count == $past(state_q.trip_count) + 8'd1))
		else $error("trip count jumped");

	// A command leaving the input register lands in the result register.
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2 && (res_s2.overcurrent_count == state_q.trip_count))
		else $error("result register missed a command");

	// An empty input register always accepts.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

endmodule
